FILE: design/vps_pkg.sv
// ----------------------------------------------------------------------------
// vps_pkg: shared types and constants for the Verlet point step unit
// Field widths, register map, configuration bundle and the request/response
// structs of the bit-serial multiplier.
// ----------------------------------------------------------------------------
package vps_pkg;

  // Q12.12 positions, Q0.16 fractions
  localparam int unsigned POS_W  = 24;
  localparam int unsigned RAD_W  = 23;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned KEEP_W = FRAC_W + 1;

  // APB register port
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  // Multiplier operands are sized for magnitudes of position differences
  localparam int unsigned MUL_W  = POS_W + 1;
  localparam int unsigned PROD_W = 2 * MUL_W + 1;
  localparam int unsigned CNT_W  = $clog2(MUL_W + 1);

  // 1.0 in Q1.16
  localparam logic [KEEP_W-1:0] ONE_Q16 = KEEP_W'(1) << FRAC_W;

  // Register index (byte address / 4)
  typedef enum logic [2:0] {
    REG_PINNED,
    REG_INIT_X,
    REG_INIT_Y,
    REG_ELASTICITY,
    REG_GRAVITY_X,
    REG_GRAVITY_Y,
    REG_DRAG,
    REG_CURSOR_RADIUS
  } reg_idx_e;

  typedef struct packed {
    logic              pinned;
    logic [POS_W-1:0]  init_x;
    logic [POS_W-1:0]  init_y;
    logic [RAD_W-1:0]  elasticity;
    logic [POS_W-1:0]  gravity_x;
    logic [POS_W-1:0]  gravity_y;
    logic [FRAC_W-1:0] drag;
    logic [RAD_W-1:0]  cursor_radius;
  } cfg_t;

  // Write of an initial-position register also loads the point state
  typedef struct packed {
    logic             load_x;
    logic             load_y;
    logic [POS_W-1:0] value;
  } cfg_load_t;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
    logic [CNT_W-1:0] nbits;
    logic             neg;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

endpackage

FILE: design/vps_in_if.sv
// ----------------------------------------------------------------------------
// vps_in_if: tick channel into the Verlet point step unit
// Valid/ready handshake carrying cursor state, button and time step.
// ----------------------------------------------------------------------------
interface vps_in_if import vps_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  cursor_x;
  logic signed [POS_W-1:0]  cursor_y;
  logic signed [POS_W-1:0]  cursor_prev_x;
  logic signed [POS_W-1:0]  cursor_prev_y;
  logic                     button_held;
  logic        [FRAC_W-1:0] time_step;

  modport source (
    output valid, cursor_x, cursor_y, cursor_prev_x, cursor_prev_y,
           button_held, time_step,
    input  ready
  );

  modport sink (
    input  valid, cursor_x, cursor_y, cursor_prev_x, cursor_prev_y,
           button_held, time_step,
    output ready
  );

endinterface

FILE: design/vps_out_if.sv
// ----------------------------------------------------------------------------
// vps_out_if: result channel out of the Verlet point step unit
// Valid/ready handshake carrying the updated position and selection flag.
// ----------------------------------------------------------------------------
interface vps_out_if import vps_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic                    selected;

  modport source (
    output valid, pos_x, pos_y, selected,
    input  ready
  );

  modport sink (
    input  valid, pos_x, pos_y, selected,
    output ready
  );

endinterface

FILE: design/vps_cfg_regs.sv
// ----------------------------------------------------------------------------
// vps_cfg_regs: APB configuration registers
// Holds the eight point parameters and flags writes of the initial position.
// ----------------------------------------------------------------------------
module vps_cfg_regs import vps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o,
  output cfg_load_t         load_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  // Decode the word address; a write completes in the access phase
  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Tell the datapath to load position and previous position
  assign load_o.load_x = wr_en && (idx == REG_INIT_X);
  assign load_o.load_y = wr_en && (idx == REG_INIT_Y);
  assign load_o.value  = pwdata[POS_W-1:0];

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_PINNED:        cfg_q.pinned        <= pwdata[0];
        REG_INIT_X:        cfg_q.init_x        <= pwdata[POS_W-1:0];
        REG_INIT_Y:        cfg_q.init_y        <= pwdata[POS_W-1:0];
        REG_ELASTICITY:    cfg_q.elasticity    <= pwdata[RAD_W-1:0];
        REG_GRAVITY_X:     cfg_q.gravity_x     <= pwdata[POS_W-1:0];
        REG_GRAVITY_Y:     cfg_q.gravity_y     <= pwdata[POS_W-1:0];
        REG_DRAG:          cfg_q.drag          <= pwdata[FRAC_W-1:0];
        REG_CURSOR_RADIUS: cfg_q.cursor_radius <= pwdata[RAD_W-1:0];
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_PINNED:        prdata = APB_DW'(cfg_q.pinned);
      REG_INIT_X:        prdata = APB_DW'(cfg_q.init_x);
      REG_INIT_Y:        prdata = APB_DW'(cfg_q.init_y);
      REG_ELASTICITY:    prdata = APB_DW'(cfg_q.elasticity);
      REG_GRAVITY_X:     prdata = APB_DW'(cfg_q.gravity_x);
      REG_GRAVITY_Y:     prdata = APB_DW'(cfg_q.gravity_y);
      REG_DRAG:          prdata = APB_DW'(cfg_q.drag);
      REG_CURSOR_RADIUS: prdata = APB_DW'(cfg_q.cursor_radius);
    endcase
  end

endmodule

FILE: design/vps_serial_mul.sv
// ----------------------------------------------------------------------------
// vps_serial_mul: bit-serial shift-add multiplier
// Retires one multiplier bit per cycle into a narrow adder, then aligns the
// product and applies the sign.
// ----------------------------------------------------------------------------
module vps_serial_mul import vps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  typedef enum logic [1:0] {
    M_IDLE,
    M_RUN,
    M_ALIGN,
    M_SIGN
  } mul_state_e;

  mul_state_e          state_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                done_q;

  logic [MUL_W:0]      hi_q;
  logic [MUL_W-1:0]    lo_q;
  logic [MUL_W-1:0]    a_q;
  logic                neg_q;
  logic [CNT_W-1:0]    shamt_q;
  logic [PROD_W-1:0]   prod_q;

  logic [MUL_W:0]      psum;
  logic [2*MUL_W-1:0]  aligned;

  // Add the multiplicand when the current multiplier bit is set
  assign psum    = hi_q + (lo_q[0] ? {1'b0, a_q} : '0);
  // Low product bits sit at the top of lo_q when fewer bits were run
  assign aligned = {hi_q[MUL_W-1:0], lo_q} >> shamt_q;

  assign rsp_o.done = done_q;
  assign rsp_o.prod = prod_q;

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        M_IDLE: begin
          if (req_i.start) begin
            cnt_q   <= req_i.nbits;
            state_q <= M_RUN;
          end
        end
        M_RUN: begin
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_q <= M_ALIGN;
          end
        end
        M_ALIGN: begin
          state_q <= M_SIGN;
        end
        M_SIGN: begin
          done_q  <= 1'b1;
          state_q <= M_IDLE;
        end
      endcase
    end
  end

  // Shift-add datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      M_IDLE: begin
        if (req_i.start) begin
          hi_q    <= '0;
          lo_q    <= req_i.b;
          a_q     <= req_i.a;
          neg_q   <= req_i.neg;
          shamt_q <= CNT_W'(MUL_W) - req_i.nbits;
        end
      end
      M_RUN: begin
        hi_q <= {1'b0, psum[MUL_W:1]};
        lo_q <= {psum[0], lo_q[MUL_W-1:1]};
      end
      M_ALIGN: begin
        prod_q <= {1'b0, aligned};
      end
      M_SIGN: begin
        if (neg_q) begin
          prod_q <= -prod_q;
        end
      end
    endcase
  end

  // A new product is only requested while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == M_IDLE)
    else $error("multiply started while busy");

  // Done is a single-cycle pulse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("multiply done held for more than one cycle");

  // The bit counter never runs out while shifting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == M_RUN |-> cnt_q != '0)
    else $error("multiply bit counter underflow");

endmodule

FILE: design/verlet_point_step_unit.sv
// ----------------------------------------------------------------------------
// verlet_point_step_unit: damped position Verlet step for one 2D point
// Each accepted tick tests cursor selection, applies cursor drag, then pins or
// integrates the point and returns the new position and the selection flag.
// ----------------------------------------------------------------------------
// All products go through a single bit-serial multiplier that retires one
// operand bit per cycle: three products for selection (radius squared, x and
// y distance squared), then dt squared, the damped gravity scale and four
// per-axis terms when the point moves. A new tick is taken once the previous
// one has finished; a finished result waits in the output register without
// holding up the next tick. Writes to init_x or init_y load both position and
// previous position and take effect at once.
module verlet_point_step_unit import vps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  vps_in_if.sink            in_i,
  vps_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned DIFF_W = POS_W + 1;
  localparam int unsigned SUM_W  = POS_W + 3;
  localparam int unsigned R2_W   = 2 * RAD_W;
  localparam int unsigned D2_W   = 2 * DIFF_W;

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_W - 1);
  localparam logic signed [SUM_W-1:0]  SAT_HI   = SUM_W'(2 ** (POS_W - 1) - 1);
  localparam logic signed [SUM_W-1:0]  SAT_LO   = SUM_W'(-(2 ** (POS_W - 1)));

  typedef enum logic [3:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_SEL,
    S_CLAMP,
    S_DRAG,
    S_DIFF,
    S_SUM,
    S_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_R2,
    OP_DX2,
    OP_DY2,
    OP_DT2,
    OP_GK,
    OP_T1X,
    OP_T1Y,
    OP_T2X,
    OP_T2Y
  } op_e;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[POS_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[POS_W-1:0];
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DIFF_W-1:0] clamp_e(input logic signed [DIFF_W-1:0] d,
                                                       input logic [RAD_W-1:0] e);
    logic signed [DIFF_W-1:0] pe;
    logic signed [DIFF_W-1:0] ne;
    logic signed [DIFF_W-1:0] r;
    pe = $signed(DIFF_W'(e));
    ne = -pe;
    if (d > pe) begin
      r = pe;
    end else if (d < ne) begin
      r = ne;
    end else begin
      r = d;
    end
    return r;
  endfunction

  // Configuration
  cfg_t      cfg;
  cfg_load_t cfg_load;

  vps_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .load_o  (cfg_load)
  );

  // Shared multiplier
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  vps_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  state_e state_q;
  op_e    op_q;
  logic   out_valid_q;

  // Point state
  logic signed [POS_W-1:0] cur_x_q, cur_y_q, old_x_q, old_y_q;

  // Per-tick working registers
  logic signed [DIFF_W-1:0] dx_q, dy_q, mdx_q, mdy_q, mx_q, my_q, vx_q, vy_q;
  logic                     btn_q;
  logic        [FRAC_W-1:0] dt_q;
  logic        [R2_W-1:0]   r2_q;
  logic        [D2_W-1:0]   d2_q;
  logic                     sel_q;
  logic        [KEEP_W-1:0] dt2_q, gk_q;
  logic signed [SUM_W-1:0]  t1x_q, t1y_q, t2x_q, t2y_q;

  // Result register
  logic signed [POS_W-1:0] out_x_q, out_y_q;
  logic                    out_sel_q;

  logic                     in_fire;
  logic                     mul_done;
  logic                     out_load;
  logic        [KEEP_W-1:0] keep;
  logic signed [DIFF_W-1:0] a_s;
  logic        [MUL_W-1:0]  a_mag;
  logic signed [PROD_W-1:0] prod_s;
  logic signed [PROD_W-1:0] rnd_sum;
  logic signed [PROD_W-1:0] rnd;

  assign in_fire  = in_i.valid & in_i.ready;
  assign mul_done = mul_rsp.done && (state_q == S_WAIT);
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_o.ready);
  assign keep     = ONE_Q16 - KEEP_W'(cfg.drag);

  // Round half up after dropping 16 fraction bits
  assign prod_s  = $signed(mul_rsp.prod);
  assign rnd_sum = prod_s + RND_HALF;
  assign rnd     = rnd_sum >>> FRAC_W;

  assign in_i.ready     = (state_q == S_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.pos_x    = out_x_q;
  assign out_o.pos_y    = out_y_q;
  assign out_o.selected = out_sel_q;

  // Select multiplier operands for the current product
  always_comb begin
    a_s           = '0;
    mul_req.b     = '0;
    mul_req.nbits = '0;
    mul_req.neg   = 1'b0;
    a_mag         = a_s[DIFF_W-1] ? MUL_W'(-a_s) : MUL_W'(a_s);
    unique case (op_q)
      OP_R2: begin
        a_s           = $signed(DIFF_W'(cfg.cursor_radius));
        a_mag         = MUL_W'(a_s);
        mul_req.b     = a_mag;
        mul_req.nbits = CNT_W'(RAD_W);
      end
      OP_DX2, OP_DY2: begin
        a_s           = (op_q == OP_DX2) ? dx_q : dy_q;
        a_mag         = a_s[DIFF_W-1] ? MUL_W'(-a_s) : MUL_W'(a_s);
        mul_req.b     = a_mag;
        mul_req.nbits = CNT_W'(MUL_W);
      end
      OP_DT2: begin
        a_s           = $signed(DIFF_W'(dt_q));
        a_mag         = MUL_W'(a_s);
        mul_req.b     = a_mag;
        mul_req.nbits = CNT_W'(FRAC_W);
      end
      OP_GK: begin
        a_s           = $signed(DIFF_W'(keep));
        a_mag         = MUL_W'(a_s);
        mul_req.b     = MUL_W'(dt2_q);
        mul_req.nbits = CNT_W'(KEEP_W);
      end
      OP_T1X, OP_T1Y: begin
        a_s           = (op_q == OP_T1X) ? vx_q : vy_q;
        a_mag         = a_s[DIFF_W-1] ? MUL_W'(-a_s) : MUL_W'(a_s);
        mul_req.b     = MUL_W'(keep);
        mul_req.nbits = CNT_W'(KEEP_W);
        mul_req.neg   = a_s[DIFF_W-1];
      end
      OP_T2X, OP_T2Y: begin
        a_s           = (op_q == OP_T2X) ? DIFF_W'($signed(cfg.gravity_x))
                                         : DIFF_W'($signed(cfg.gravity_y));
        a_mag         = a_s[DIFF_W-1] ? MUL_W'(-a_s) : MUL_W'(a_s);
        mul_req.b     = MUL_W'(gk_q);
        mul_req.nbits = CNT_W'(KEEP_W);
        mul_req.neg   = a_s[DIFF_W-1];
      end
      default: begin
        a_s = '0;
      end
    endcase
    mul_req.start = (state_q == S_ISSUE);
    mul_req.a     = a_mag;
  end

  // Tick sequencer and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_R2;
      out_valid_q <= 1'b0;
    end else begin
      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            op_q    <= OP_R2;
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (mul_done) begin
            unique case (op_q)
              OP_R2:   begin op_q <= OP_DX2; state_q <= S_ISSUE; end
              OP_DX2:  begin op_q <= OP_DY2; state_q <= S_ISSUE; end
              OP_DY2:  state_q <= S_SEL;
              OP_DT2:  begin op_q <= OP_GK;  state_q <= S_ISSUE; end
              OP_GK:   begin op_q <= OP_T1X; state_q <= S_ISSUE; end
              OP_T1X:  begin op_q <= OP_T1Y; state_q <= S_ISSUE; end
              OP_T1Y:  begin op_q <= OP_T2X; state_q <= S_ISSUE; end
              OP_T2X:  begin op_q <= OP_T2Y; state_q <= S_ISSUE; end
              OP_T2Y:  state_q <= S_SUM;
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_SEL: begin
          state_q <= S_CLAMP;
        end
        S_CLAMP: begin
          state_q <= S_DRAG;
        end
        S_DRAG: begin
          state_q <= cfg.pinned ? S_DONE : S_DIFF;
        end
        S_DIFF: begin
          op_q    <= OP_DT2;
          state_q <= S_ISSUE;
        end
        S_SUM: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Point position and previous position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0;
      cur_y_q <= '0;
      old_x_q <= '0;
      old_y_q <= '0;
    end else begin
      if (cfg_load.load_x) begin
        cur_x_q <= $signed(cfg_load.value);
        old_x_q <= $signed(cfg_load.value);
      end
      if (cfg_load.load_y) begin
        cur_y_q <= $signed(cfg_load.value);
        old_y_q <= $signed(cfg_load.value);
      end
      // Drag the previous position with the cursor, then pin
      if (state_q == S_DRAG) begin
        if (btn_q && sel_q) begin
          old_x_q <= sat_pos(SUM_W'(cur_x_q) - SUM_W'(mx_q));
          old_y_q <= sat_pos(SUM_W'(cur_y_q) - SUM_W'(my_q));
        end
        if (cfg.pinned) begin
          cur_x_q <= $signed(cfg.init_x);
          cur_y_q <= $signed(cfg.init_y);
        end
      end
      // Advance the point
      if (state_q == S_SUM) begin
        old_x_q <= cur_x_q;
        old_y_q <= cur_y_q;
        cur_x_q <= sat_pos(SUM_W'(cur_x_q) + t1x_q + t2x_q);
        cur_y_q <= sat_pos(SUM_W'(cur_y_q) + t1y_q + t2y_q);
      end
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dx_q  <= DIFF_W'(cur_x_q) - DIFF_W'(in_i.cursor_x);
      dy_q  <= DIFF_W'(cur_y_q) - DIFF_W'(in_i.cursor_y);
      mdx_q <= DIFF_W'(in_i.cursor_x) - DIFF_W'(in_i.cursor_prev_x);
      mdy_q <= DIFF_W'(in_i.cursor_y) - DIFF_W'(in_i.cursor_prev_y);
      btn_q <= in_i.button_held;
      dt_q  <= in_i.time_step;
    end
    if (mul_done) begin
      unique case (op_q)
        OP_R2:   r2_q  <= mul_rsp.prod[R2_W-1:0];
        OP_DX2:  d2_q  <= mul_rsp.prod[D2_W-1:0];
        OP_DY2:  d2_q  <= d2_q + mul_rsp.prod[D2_W-1:0];
        OP_DT2:  dt2_q <= rnd[KEEP_W-1:0];
        OP_GK:   gk_q  <= rnd[KEEP_W-1:0];
        OP_T1X:  t1x_q <= SUM_W'(rnd);
        OP_T1Y:  t1y_q <= SUM_W'(rnd);
        OP_T2X:  t2x_q <= SUM_W'(rnd);
        OP_T2Y:  t2y_q <= SUM_W'(rnd);
        default: d2_q  <= d2_q;
      endcase
    end
    // Strictly inside the radius
    if (state_q == S_SEL) begin
      sel_q <= d2_q < D2_W'(r2_q);
    end
    if (state_q == S_CLAMP) begin
      mx_q <= clamp_e(mdx_q, cfg.elasticity);
      my_q <= clamp_e(mdy_q, cfg.elasticity);
    end
    // Velocity from the possibly dragged previous position
    if (state_q == S_DIFF) begin
      vx_q <= DIFF_W'(cur_x_q) - DIFF_W'(old_x_q);
      vy_q <= DIFF_W'(cur_y_q) - DIFF_W'(old_y_q);
    end
    if (out_load) begin
      out_x_q   <= cur_x_q;
      out_y_q   <= cur_y_q;
      out_sel_q <= sel_q;
    end
  end

  // Products only come back while the sequencer waits for one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> state_q == S_WAIT)
    else $error("multiplier result outside of wait state");

  // Every tick starts with the radius product
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_ISSUE) && (op_q == OP_R2))
    else $error("tick did not start selection");

  // A pinned point lands on its initial position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAG) && cfg.pinned
      |=> (cur_x_q == $past(cfg.init_x)) && (cur_y_q == $past(cfg.init_y)))
    else $error("pinned point not at initial position");

  // Loading the result register always presents it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("result loaded but not presented");

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Verlet point step unit
// Drives cursor ticks over the valid/ready input channel and programs the
// registers over APB while the unit is idle. A fixed-point predictor tracks
// the point position, its history and the register copies, and works out the
// expected position and selection flag for each accepted tick. The monitor
// compares every result transfer field by field against the oldest
// expectation. A short directed run hits the rails, the clamp, the radius
// boundary, pinning and zero radius; random ticks follow, mostly aimed at the
// point so that selection and dragging happen often.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import vps_pkg::*;

  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned SETTLE_CYCLES = 250;
  localparam int unsigned BATCHES       = 12;
  localparam int unsigned BATCH_TICKS   = 96;
  localparam int unsigned REPORT_LINES  = 100;
  localparam longint      POS_HI        = 8388607;
  localparam longint      POS_LO        = -8388608;

  typedef struct {
    logic signed [POS_W-1:0] cursor_x;
    logic signed [POS_W-1:0] cursor_y;
    logic signed [POS_W-1:0] cursor_prev_x;
    logic signed [POS_W-1:0] cursor_prev_y;
    logic                    button_held;
    logic [FRAC_W-1:0]       time_step;
  } tick_t;

  typedef struct {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    selected;
  } point_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  vps_in_if  tick_if ();
  vps_out_if point_if ();

  verlet_point_step_unit u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (tick_if),
    .out_o   (point_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Pending ticks, the tick on the bus, and expected point results
  tick_t  tick_q[$];
  tick_t  held_tick;
  point_t point_results_q[$];

  // Predicted point state and register copies
  logic signed [POS_W-1:0] pt_cur_x, pt_cur_y, pt_old_x, pt_old_y;
  logic                    cfg_pinned;
  logic signed [POS_W-1:0] cfg_init_x, cfg_init_y, cfg_gravity_x, cfg_gravity_y;
  logic [RAD_W-1:0]        cfg_elasticity, cfg_radius;
  logic [FRAC_W-1:0]       cfg_drag;

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned mismatch_cnt;
  int unsigned results_seen;
  int unsigned idle_cycles;

  // Round half up at the Q16 boundary (floor of v/2^16 + 1/2)
  function automatic longint round_q16(input longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic longint clip_pos(input longint v);
    if (v > POS_HI) return POS_HI;
    if (v < POS_LO) return POS_LO;
    return v;
  endfunction

  function automatic longint clamp_motion(input longint d, input longint e);
    if (d > e) return e;
    if (d < -e) return -e;
    return d;
  endfunction

  function automatic longint rand_sym(input longint m);
    return longint'($urandom_range(0, 32'(2 * m))) - m;
  endfunction

  function automatic longint rand_pos();
    logic signed [POS_W-1:0] v;
    v = POS_W'($urandom);
    return v;
  endfunction

  // Extremes one time in ten each, otherwise a typical range
  function automatic longint pick_value(input longint lo, input longint hi,
                                        input longint typ_lo, input longint typ_hi);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return typ_lo + longint'($urandom_range(0, 32'(typ_hi - typ_lo)));
  endfunction

  function automatic logic [APB_DW-1:0] pos_word(input longint v);
    logic [APB_DW-1:0] w;
    w = '0;
    w[POS_W-1:0] = v[POS_W-1:0];
    return w;
  endfunction

  // Advance the predicted point by one tick and return the expected result
  task automatic advance_point(input tick_t t, output point_t r);
    longint cx, cy, cur_x, cur_y, dx, dy, mx, my, keep, dt2, gk, nx, ny;
    logic   sel;
    cx    = t.cursor_x;
    cy    = t.cursor_y;
    cur_x = pt_cur_x;
    cur_y = pt_cur_y;
    dx    = cur_x - cx;
    dy    = cur_y - cy;
    sel   = (dx * dx + dy * dy) < (longint'(cfg_radius) * longint'(cfg_radius));
    // Drag: history follows the clamped cursor motion
    if (t.button_held && sel) begin
      mx       = clamp_motion(cx - longint'(t.cursor_prev_x), longint'(cfg_elasticity));
      my       = clamp_motion(cy - longint'(t.cursor_prev_y), longint'(cfg_elasticity));
      pt_old_x = clip_pos(cur_x - mx);
      pt_old_y = clip_pos(cur_y - my);
    end
    if (cfg_pinned) begin
      pt_cur_x = cfg_init_x;
      pt_cur_y = cfg_init_y;
    end else begin
      keep     = 65536 - longint'(cfg_drag);
      dt2      = round_q16(longint'(t.time_step) * longint'(t.time_step));
      gk       = round_q16(keep * dt2);
      nx       = cur_x + round_q16((cur_x - longint'(pt_old_x)) * keep)
                       + round_q16(longint'(cfg_gravity_x) * gk);
      ny       = cur_y + round_q16((cur_y - longint'(pt_old_y)) * keep)
                       + round_q16(longint'(cfg_gravity_y) * gk);
      pt_old_x = pt_cur_x;
      pt_old_y = pt_cur_y;
      pt_cur_x = clip_pos(nx);
      pt_cur_y = clip_pos(ny);
    end
    r.pos_x    = pt_cur_x;
    r.pos_y    = pt_cur_y;
    r.selected = sel;
  endtask

  task automatic flag_mismatch(input string field, input longint got, input longint want);
    if (mismatch_cnt < REPORT_LINES)
      $display("error: result %0d field %s got %0d expected %0d",
               results_seen, field, got, want);
    mismatch_cnt++;
  endtask

  // Hold until no tick is pending and no result is outstanding
  task automatic wait_drained();
    while (tick_q.size() != 0 || tick_if.valid || point_results_q.size() != 0)
      @(negedge clk);
  endtask

  // APB write while idle; update the register copies at the access edge
  task automatic write_reg(input reg_idx_e idx, input logic [APB_DW-1:0] value);
    wait_drained();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PINNED:        cfg_pinned = value[0];
      REG_INIT_X: begin
        cfg_init_x = value[POS_W-1:0];
        pt_cur_x   = cfg_init_x;
        pt_old_x   = cfg_init_x;
      end
      REG_INIT_Y: begin
        cfg_init_y = value[POS_W-1:0];
        pt_cur_y   = cfg_init_y;
        pt_old_y   = cfg_init_y;
      end
      REG_ELASTICITY:    cfg_elasticity = value[RAD_W-1:0];
      REG_GRAVITY_X:     cfg_gravity_x  = value[POS_W-1:0];
      REG_GRAVITY_Y:     cfg_gravity_y  = value[POS_W-1:0];
      REG_DRAG:          cfg_drag       = value[FRAC_W-1:0];
      REG_CURSOR_RADIUS: cfg_radius     = value[RAD_W-1:0];
      default: ;
    endcase
  endtask

  // Queue one tick and hold until it is transferred, so the predicted
  // state is current when the next tick is built
  task automatic queue_tick(input longint cx, input longint cy, input longint px,
                            input longint py, input logic btn, input longint dt);
    tick_t tk;
    tk.cursor_x      = clip_pos(cx);
    tk.cursor_y      = clip_pos(cy);
    tk.cursor_prev_x = clip_pos(px);
    tk.cursor_prev_y = clip_pos(py);
    tk.button_held   = btn;
    tk.time_step     = dt[FRAC_W-1:0];
    tick_q.push_back(tk);
    do @(negedge clk); while (tick_q.size() != 0 || tick_if.valid);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Tick driver: predict on each transfer, then present the next tick
  always @(posedge clk) begin
    point_t next_point;
    if (rst_n) begin
      if (tick_if.valid && tick_if.ready) begin
        advance_point(held_tick, next_point);
        point_results_q.push_back(next_point);
      end
      if (!tick_if.valid || tick_if.ready) begin
        if (tick_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          held_tick               = tick_q.pop_front();
          tick_if.valid          <= 1'b1;
          tick_if.cursor_x       <= held_tick.cursor_x;
          tick_if.cursor_y       <= held_tick.cursor_y;
          tick_if.cursor_prev_x  <= held_tick.cursor_prev_x;
          tick_if.cursor_prev_y  <= held_tick.cursor_prev_y;
          tick_if.button_held    <= held_tick.button_held;
          tick_if.time_step      <= held_tick.time_step;
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random backpressure, compare each transfer
  always @(posedge clk) begin
    point_t want;
    if (rst_n) begin
      point_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      if (point_if.valid && point_if.ready) begin
        results_seen++;
        if (point_results_q.size() == 0) begin
          flag_mismatch("unexpected", 1, 0);
        end else begin
          want = point_results_q.pop_front();
          if (point_if.pos_x !== want.pos_x)
            flag_mismatch("pos_x", point_if.pos_x, want.pos_x);
          if (point_if.pos_y !== want.pos_y)
            flag_mismatch("pos_y", point_if.pos_y, want.pos_y);
          if (point_if.selected !== want.selected)
            flag_mismatch("selected", point_if.selected, want.selected);
        end
      end
    end
  end

  // Watchdog: count cycles without any transfer or register access
  always @(posedge clk) begin
    if (rst_n) begin
      if ((tick_if.valid && tick_if.ready) || (point_if.valid && point_if.ready) || psel)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    longint cx, cy, px, py, span, reach, dt;
    logic   btn;
    rst_n                 = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    tick_if.valid         = 1'b0;
    tick_if.cursor_x      = '0;
    tick_if.cursor_y      = '0;
    tick_if.cursor_prev_x = '0;
    tick_if.cursor_prev_y = '0;
    tick_if.button_held   = 1'b0;
    tick_if.time_step     = '0;
    point_if.ready        = 1'b0;
    pt_cur_x              = '0;
    pt_cur_y              = '0;
    pt_old_x              = '0;
    pt_old_y              = '0;
    cfg_pinned            = 1'b0;
    cfg_init_x            = '0;
    cfg_init_y            = '0;
    cfg_elasticity        = '0;
    cfg_gravity_x         = '0;
    cfg_gravity_y         = '0;
    cfg_drag              = '0;
    cfg_radius            = '0;
    src_idle_pct          = 37;
    snk_idle_pct          = 52;
    mismatch_cnt          = 0;
    results_seen          = 0;
    idle_cycles           = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Baseline: free fall, light drag, mid-size radius
    write_reg(REG_PINNED, 0);
    write_reg(REG_INIT_X, 0);
    write_reg(REG_INIT_Y, 0);
    write_reg(REG_ELASTICITY, 'h800);
    write_reg(REG_GRAVITY_X, 0);
    write_reg(REG_GRAVITY_Y, pos_word(-40141));
    write_reg(REG_DRAG, 'h100);
    write_reg(REG_CURSOR_RADIUS, 'h2000);
    // cursor far away: plain integration
    queue_tick(1048576, 1048576, 1048576, 1048576, 0, 'h444);
    // grab with motion beyond the clamp on both axes
    queue_tick(pt_cur_x + 256, pt_cur_y, pt_cur_x + 256 - 65536, pt_cur_y + 65536, 1, 'h444);
    // grab with no motion and a zero time step
    queue_tick(pt_cur_x, pt_cur_y, pt_cur_x, pt_cur_y, 1, 0);
    // longest time step
    queue_tick(1048576, -1048576, 0, 0, 0, 'hFFFF);
    // cursor fields at their extremes, outside the radius
    queue_tick(POS_HI, POS_LO, POS_LO, POS_HI, 1, 'hFFFF);

    // Widest radius and clamp: full-scale grab
    write_reg(REG_CURSOR_RADIUS, 'h7F_FFFF);
    write_reg(REG_ELASTICITY, 'h7F_FFFF);
    queue_tick(pt_cur_x + 6291456, pt_cur_y - 4194304, POS_LO, POS_HI, 1, 'h1000);
    queue_tick(0, 0, 0, 0, 0, 'h2000);

    // Rails: start next to the limits, drag and fall outward
    write_reg(REG_INIT_X, pos_word(POS_HI - 16));
    write_reg(REG_INIT_Y, pos_word(POS_LO + 16));
    write_reg(REG_GRAVITY_X, pos_word(POS_HI));
    write_reg(REG_GRAVITY_Y, pos_word(POS_LO));
    write_reg(REG_DRAG, 0);
    queue_tick(pt_cur_x - 4194304, pt_cur_y + 4194304, POS_HI, POS_LO, 1, 'hFFFF);
    queue_tick(0, 0, 0, 0, 0, 'hFFFF);

    // Full damping
    write_reg(REG_DRAG, 'hFFFF);
    queue_tick(0, 0, 0, 0, 0, 'h8000);

    // Zero radius: a cursor right on the point selects nothing
    write_reg(REG_CURSOR_RADIUS, 0);
    write_reg(REG_INIT_X, 0);
    write_reg(REG_INIT_Y, 0);
    write_reg(REG_GRAVITY_X, 'h1000);
    write_reg(REG_GRAVITY_Y, pos_word(-4096));
    write_reg(REG_DRAG, 'h80);
    queue_tick(pt_cur_x, pt_cur_y, pt_cur_x - 16, pt_cur_y, 1, 'h1000);

    // Pinned while dragged: history keeps the dragged value
    write_reg(REG_CURSOR_RADIUS, 'h4000);
    write_reg(REG_ELASTICITY, 'h2000);
    write_reg(REG_INIT_X, 'h1000);
    write_reg(REG_INIT_Y, pos_word(-4096));
    write_reg(REG_PINNED, 1);
    queue_tick(pt_cur_x + 512, pt_cur_y - 512, pt_cur_x + 512 - 12288,
               pt_cur_y - 512 + 12288, 1, 'h1000);
    queue_tick(pt_cur_x, pt_cur_y, pt_cur_x, pt_cur_y, 0, 'h1000);

    // Release: dragged history turns into velocity
    write_reg(REG_PINNED, 0);
    queue_tick(1048576, 1048576, 0, 0, 0, 'h444);
    // radius boundary: on the circle is outside, one LSB in is inside
    queue_tick(pt_cur_x + 16384, pt_cur_y, 0, 0, 1, 'h444);
    queue_tick(pt_cur_x + 16383, pt_cur_y, 0, 0, 1, 'h444);
    // selected without the button: no drag
    queue_tick(pt_cur_x, pt_cur_y, POS_LO, POS_HI, 0, 'h444);

    // Random batches, each under a fresh register setting
    for (int b = 0; b < BATCHES; b++) begin
      case (b / 4)
        0: begin
          src_idle_pct = 37;
          snk_idle_pct = 52;
        end
        1: begin
          src_idle_pct = 52;
          snk_idle_pct = 37;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      write_reg(REG_PINNED, $urandom_range(0, 99) < 15);
      if (b == 0 || $urandom_range(0, 1) == 1) begin
        write_reg(REG_INIT_X, pos_word(pick_value(POS_LO, POS_HI, -1048576, 1048576)));
        write_reg(REG_INIT_Y, pos_word(pick_value(POS_LO, POS_HI, -1048576, 1048576)));
      end
      write_reg(REG_ELASTICITY, 32'(pick_value(0, 'h7F_FFFF, 0, 'h8000)));
      write_reg(REG_GRAVITY_X, pos_word(pick_value(POS_LO, POS_HI, -262144, 262144)));
      write_reg(REG_GRAVITY_Y, pos_word(pick_value(POS_LO, POS_HI, -262144, 262144)));
      write_reg(REG_DRAG, 32'(pick_value(0, 'hFFFF, 0, 'h4000)));
      write_reg(REG_CURSOR_RADIUS, 32'(pick_value(0, 'h7F_FFFF, 'h400, 'h40000)));

      for (int i = 0; i < BATCH_TICKS; i++) begin
        // occasionally hold off until every result is back
        if ($urandom_range(0, 99) < 3)
          wait_drained();
        if ($urandom_range(0, 99) < 72) begin
          // aim at the point with motion around the clamp
          span  = longint'(cfg_radius) + longint'(cfg_radius) / 4 + 64;
          cx    = pt_cur_x + rand_sym(span);
          cy    = pt_cur_y + rand_sym(span);
          reach = 2 * longint'(cfg_elasticity) + 64;
          if ($urandom_range(0, 9) == 0)
            reach = 16777216;
          px    = cx - rand_sym(reach);
          py    = cy - rand_sym(reach);
          btn   = ($urandom_range(0, 3) != 0);
          if ($urandom_range(0, 7) == 0)
            dt = $urandom_range(0, 'hFFFF);
          else
            dt = $urandom_range(0, 'h1000);
        end else begin
          cx  = rand_pos();
          cy  = rand_pos();
          px  = rand_pos();
          py  = rand_pos();
          btn = $urandom_range(0, 1);
          dt  = $urandom_range(0, 'hFFFF);
        end
        queue_tick(cx, cy, px, py, btn, dt);
      end
    end

    // Drain, let any stray result show up, then report
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
